FILE: design/interval_timer_running_stats_assert.svh
// Assertion macros shared by the interval timer checker.
`ifndef INTERVAL_TIMER_RUNNING_STATS_ASSERT_SVH
`define INTERVAL_TIMER_RUNNING_STATS_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ITS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ITS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/its_pkg.sv
// Shared constants, op codes and store control type for the interval timer bank.
package its_pkg;

    localparam int OP_W       = 2;
    localparam int SLOT_W     = 5;
    localparam int TS_W       = 32;
    localparam int CNT_W      = 32;
    localparam int MEAN_OUT_W = 48;
    localparam int DEV_W      = 64;
    localparam int ELAP_W     = 32;
    localparam int HALF_W     = 32;
    localparam int PROD_W     = 4 * HALF_W;
    localparam int MAX_SLOTS  = 2 ** SLOT_W;

    localparam int DEF_NUM_SLOTS      = 32;
    localparam int DEF_MEAN_FRAC_BITS = 16;
    localparam int DEF_TIME_WIDTH     = 32;
    localparam int DEF_MEAN_W         = DEF_TIME_WIDTH + DEF_MEAN_FRAC_BITS;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              clr_en;
        logic [SLOT_W-1:0] addr;
    } t_mem_ctl;

endpackage

FILE: design/its_store.sv
// Per-slot statistics memory with valid bits that read unwritten rows as zero.
module its_store import its_pkg::*; #(
    parameter int DEPTH = DEF_NUM_SLOTS,
    parameter int AW    = 5,
    parameter int ROW_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mem_ctl         i_ctl,
    input  logic [ROW_W-1:0] i_wr_row,
    output logic [ROW_W-1:0] o_rd_row
);

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [ROW_W-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [AW-1:0]    addr;

    assign addr     = i_ctl.addr[AW-1:0];
    assign o_rd_row = r_rd_vld ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[addr] <= i_wr_row;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    // Valid bits: reset clears every row at once, clear drops one row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[addr] <= 1'b1;
            end else if (i_ctl.clr_en) begin
                r_vld[addr] <= 1'b0;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[addr];
            end
        end
    end

endmodule

FILE: design/its_div.sv
// Restoring divider, one quotient bit per cycle.
module its_div import its_pkg::*; #(
    parameter int W = DEF_MEAN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W-1:0]     i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [W-1:0]     o_quotient
);

    localparam int CW = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div;
    logic [W-1:0]     r_quo;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic             ge;

    assign trial      = {r_rem, r_quo[W-1]};
    assign diff       = trial - {1'b0, r_div};
    assign ge         = trial >= {1'b0, r_div};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_cnt  <= CW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // Shift in the next dividend bit, subtract when it fits.
                r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                r_quo <= {r_quo[W-2:0], ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: design/its_mul.sv
// Multiplier built from four 32x32 partial products accumulated over cycles.
module its_mul import its_pkg::*; #(
    parameter int W = DEF_MEAN_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_product
);

    logic [2*HALF_W-1:0] r_a;
    logic [2*HALF_W-1:0] r_b;
    logic [1:0]          r_k;
    logic                r_issue;
    logic                r_pp_vld;
    logic                r_done;
    logic [2*HALF_W-1:0] r_pp;
    logic [1:0]          r_sh;
    logic [PROD_W-1:0]   r_acc;
    logic [HALF_W-1:0]   a_half;
    logic [HALF_W-1:0]   b_half;
    logic [PROD_W-1:0]   pp_shifted;

    assign a_half    = r_k[0] ? r_a[2*HALF_W-1:HALF_W] : r_a[HALF_W-1:0];
    assign b_half    = r_k[1] ? r_b[2*HALF_W-1:HALF_W] : r_b[HALF_W-1:0];
    assign o_done    = r_done;
    assign o_product = r_acc;

    always_comb begin
        case (r_sh)
            2'd0:    pp_shifted = PROD_W'(r_pp);
            2'd1:    pp_shifted = PROD_W'(r_pp) << HALF_W;
            default: pp_shifted = PROD_W'(r_pp) << (2 * HALF_W);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= 1'b0;
            r_pp_vld <= 1'b0;
            r_done   <= 1'b0;
            r_k      <= '0;
        end else begin
            r_done <= r_pp_vld && !r_issue;
            if (i_start) begin
                r_a      <= (2*HALF_W)'(i_a);
                r_b      <= (2*HALF_W)'(i_b);
                r_k      <= '0;
                r_issue  <= 1'b1;
                r_pp_vld <= 1'b0;
                r_acc    <= '0;
                r_done   <= 1'b0;
            end else begin
                if (r_pp_vld) begin
                    r_acc <= r_acc + pp_shifted;
                end
                if (r_issue) begin
                    r_pp     <= a_half * b_half;
                    r_sh     <= 2'(r_k[0]) + 2'(r_k[1]);
                    r_pp_vld <= 1'b1;
                    r_k      <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_issue <= 1'b0;
                    end
                end else begin
                    r_pp_vld <= 1'b0;
                end
            end
        end
    end

endmodule

FILE: design/interval_timer_running_stats.sv
// Top level of the interval timer bank with per-slot running statistics.
//
// Input channel (i_in_valid / o_in_stall) takes one word per event: an op
// (start, stop, clear), a slot and a timestamp. The output channel
// (o_out_valid / i_out_stall) returns exactly one word per input word with
// the slot's count, mean, squared-deviation sum, minimum and maximum.
// o_in_stall is high whenever the sequencer is not idle, so one word is
// worked on at a time.
// Steps: start, clear, a first-sample or non-updating stop and out-of-range
// slots go from S_LOAD straight to S_OUT. A stop that adds a second or
// later sample runs S_LOAD, S_PREP, S_DIV, S_D2, S_MUL and S_OUT in order;
// S_DIV waits on the iterative divider, one quotient bit per cycle over the
// mean width, and S_MUL waits on four partial products.
// The result sits in an output register; the next word is accepted while it
// waits. If i_out_stall holds a result, the following word is finished and
// then held in the last sequencer state until the output register frees.
// Reset (i_rst_n low, synchronous) clears the valid bits of every slot at
// once, so all slots read as idle with zero statistics; no clearing pass.
module interval_timer_running_stats import its_pkg::*; #(
    parameter int NUM_SLOTS      = DEF_NUM_SLOTS,
    parameter int MEAN_FRAC_BITS = DEF_MEAN_FRAC_BITS,
    parameter int TIME_WIDTH     = DEF_TIME_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_op,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [TS_W-1:0]       i_timestamp,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SLOT_W-1:0]     o_slot_out,
    output logic                  o_updated,
    output logic [CNT_W-1:0]      o_sample_count,
    output logic [MEAN_OUT_W-1:0] o_mean_fixed,
    output logic [DEV_W-1:0]      o_sq_dev_sum,
    output logic [ELAP_W-1:0]     o_min_elapsed,
    output logic [ELAP_W-1:0]     o_max_elapsed
);

    // Timestamp bits in use, mean width and slot memory shape.
    localparam int TIME_BITS = (TIME_WIDTH < TS_W) ? TIME_WIDTH : TS_W;
    localparam int MW        = TIME_BITS + MEAN_FRAC_BITS;
    localparam int DEPTH     = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Product of two mean-scale values carries 2F fraction bits; bring it to 8.
    localparam int SH_R = (2 * MEAN_FRAC_BITS > 8) ? 2 * MEAN_FRAC_BITS - 8 : 0;
    localparam int SH_L = (2 * MEAN_FRAC_BITS < 8) ? 8 - 2 * MEAN_FRAC_BITS : 0;

    // Row layout, least significant field first.
    localparam int MAX_LSB   = 0;
    localparam int MIN_LSB   = MAX_LSB + TIME_BITS;
    localparam int DEV_LSB   = MIN_LSB + TIME_BITS;
    localparam int MEAN_LSB  = DEV_LSB + DEV_W;
    localparam int CNT_LSB   = MEAN_LSB + MW;
    localparam int RUN_LSB   = CNT_LSB + CNT_W;
    localparam int START_LSB = RUN_LSB + 1;
    localparam int ROW_W     = START_LSB + TIME_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_PREP,
        S_DIV,
        S_D2,
        S_MUL,
        S_OUT
    } t_state;

    // Sequencer and working registers.
    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [TIME_BITS-1:0]  r_ts, n_ts;
    logic                  r_in_range, n_in_range;
    logic [TIME_BITS-1:0]  r_start, n_start;
    logic                  r_running, n_running;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [MW-1:0]         r_mean, n_mean;
    logic [DEV_W-1:0]      r_dev, n_dev;
    logic [TIME_BITS-1:0]  r_min, n_min;
    logic [TIME_BITS-1:0]  r_max, n_max;
    logic [TIME_BITS-1:0]  r_elapsed, n_elapsed;
    logic                  r_up, n_up;
    logic [MW-1:0]         r_d, n_d;
    logic                  r_upd, n_upd;
    logic                  r_do_wr, n_do_wr;
    logic                  r_do_clr, n_do_clr;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]     r_o_slot, n_o_slot;
    logic                  r_o_upd, n_o_upd;
    logic [CNT_W-1:0]      r_o_count, n_o_count;
    logic [MEAN_OUT_W-1:0] r_o_mean, n_o_mean;
    logic [DEV_W-1:0]      r_o_dev, n_o_dev;
    logic [ELAP_W-1:0]     r_o_min, n_o_min;
    logic [ELAP_W-1:0]     r_o_max, n_o_max;

    // Memory, divider and multiplier hookup.
    t_mem_ctl              mem_ctl;
    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      wr_row;
    logic                  div_start;
    logic                  div_done;
    logic [MW-1:0]         div_q;
    logic                  mul_start;
    logic                  mul_done;
    logic [PROD_W-1:0]     mul_p;

    // Combinational helpers.
    logic [TIME_BITS-1:0]  rd_start, rd_min, rd_max, ld_elapsed;
    logic                  rd_running, ld_ok;
    logic [CNT_W-1:0]      rd_count;
    logic [MW-1:0]         rd_mean;
    logic [DEV_W-1:0]      rd_dev;
    logic                  ld_keep;
    logic [MW-1:0]         e_val, d_val, nm_val, d2_val;
    logic                  d_up;
    logic [PROD_W-1:0]     scaled;
    logic [DEV_W-1:0]      add_val;
    logic [DEV_W:0]        sum_val;
    logic                  out_free;

    assign rd_start   = rd_row[START_LSB +: TIME_BITS];
    assign rd_running = rd_row[RUN_LSB];
    assign rd_count   = rd_row[CNT_LSB +: CNT_W];
    assign rd_mean    = rd_row[MEAN_LSB +: MW];
    assign rd_dev     = rd_row[DEV_LSB +: DEV_W];
    assign rd_min     = rd_row[MIN_LSB +: TIME_BITS];
    assign rd_max     = rd_row[MAX_LSB +: TIME_BITS];
    assign wr_row     = {r_start, r_running, r_count, r_mean, r_dev, r_min, r_max};

    its_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .ROW_W (ROW_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mem_ctl),
        .i_wr_row (wr_row),
        .o_rd_row (rd_row)
    );

    its_div #(
        .W (MW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (d_val),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    its_mul #(
        .W (MW)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (r_d),
        .i_b       (d2_val),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_slot_out     = r_o_slot;
    assign o_updated      = r_o_upd;
    assign o_sample_count = r_o_count;
    assign o_mean_fixed   = r_o_mean;
    assign o_sq_dev_sum   = r_o_dev;
    assign o_min_elapsed  = r_o_min;
    assign o_max_elapsed  = r_o_max;

    // Datapath pieces shared across sequencer steps.
    always_comb begin
        // Sample value at mean scale, and its distance from the running mean.
        e_val  = MW'(r_elapsed) << MEAN_FRAC_BITS;
        d_up   = e_val >= r_mean;
        d_val  = d_up ? e_val - r_mean : r_mean - e_val;
        nm_val = r_up ? r_mean + div_q : r_mean - div_q;
        // r_mean already holds the new mean when this is used.
        d2_val = r_up ? e_val - r_mean : r_mean - e_val;
        // Rescale the product, saturate it, then add with saturation.
        scaled  = (mul_p >> SH_R) << SH_L;
        add_val = (|scaled[PROD_W-1:DEV_W]) ? '1 : scaled[DEV_W-1:0];
        sum_val = {1'b0, r_dev} + {1'b0, add_val};
        // Row fields as loaded: zero for clear or an out-of-range slot.
        ld_keep    = r_in_range && (r_op != OP_CLEAR);
        ld_elapsed = r_ts - rd_start;
        ld_ok      = rd_running && (r_ts >= rd_start);
        out_free   = !r_out_valid || !i_out_stall;
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_slot      = r_slot;
        n_ts        = r_ts;
        n_in_range  = r_in_range;
        n_start     = r_start;
        n_running   = r_running;
        n_count     = r_count;
        n_mean      = r_mean;
        n_dev       = r_dev;
        n_min       = r_min;
        n_max       = r_max;
        n_elapsed   = r_elapsed;
        n_up        = r_up;
        n_d         = r_d;
        n_upd       = r_upd;
        n_do_wr     = r_do_wr;
        n_do_clr    = r_do_clr;
        n_out_valid = r_out_valid;
        n_o_slot    = r_o_slot;
        n_o_upd     = r_o_upd;
        n_o_count   = r_o_count;
        n_o_mean    = r_o_mean;
        n_o_dev     = r_o_dev;
        n_o_min     = r_o_min;
        n_o_max     = r_o_max;
        mem_ctl     = '0;
        div_start   = 1'b0;
        mul_start   = 1'b0;

        // Drop the result once the receiver takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = t_op'(i_op);
                    n_slot       = i_slot;
                    n_ts         = i_timestamp[TIME_BITS-1:0];
                    n_in_range   = (32'(i_slot) < 32'(DEPTH));
                    n_upd        = 1'b0;
                    n_do_wr      = 1'b0;
                    n_do_clr     = 1'b0;
                    mem_ctl.rd_en = 1'b1;
                    mem_ctl.addr  = i_slot;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                n_start   = ld_keep ? rd_start : '0;
                n_running = ld_keep ? rd_running : 1'b0;
                n_count   = ld_keep ? rd_count : '0;
                n_mean    = ld_keep ? rd_mean : '0;
                n_dev     = ld_keep ? rd_dev : '0;
                n_min     = ld_keep ? rd_min : '0;
                n_max     = ld_keep ? rd_max : '0;
                n_state   = S_OUT;
                if (r_in_range) begin
                    unique case (r_op)
                        OP_START: begin
                            n_start   = r_ts;
                            n_running = 1'b1;
                            n_do_wr   = 1'b1;
                        end
                        OP_STOP: begin
                            if (ld_ok) begin
                                n_upd     = 1'b1;
                                n_do_wr   = 1'b1;
                                n_elapsed = ld_elapsed;
                                if (rd_count == '0) begin
                                    // First sample seeds every statistic.
                                    n_count = CNT_W'(1);
                                    n_mean  = MW'(ld_elapsed) << MEAN_FRAC_BITS;
                                    n_dev   = '0;
                                    n_min   = ld_elapsed;
                                    n_max   = ld_elapsed;
                                end else begin
                                    // Hold the count at its ceiling.
                                    n_count = (&rd_count) ? rd_count : rd_count + CNT_W'(1);
                                    n_state = S_PREP;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_do_clr = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PREP: begin
                n_up      = d_up;
                n_d       = d_val;
                div_start = 1'b1;
                if (r_elapsed < r_min) begin
                    n_min = r_elapsed;
                end
                if (r_elapsed > r_max) begin
                    n_max = r_elapsed;
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_mean  = nm_val;
                    n_state = S_D2;
                end
            end
            S_D2: begin
                mul_start = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                if (mul_done) begin
                    n_dev   = sum_val[DEV_W] ? '1 : sum_val[DEV_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    mem_ctl.wr_en  = r_do_wr;
                    mem_ctl.clr_en = r_do_clr;
                    mem_ctl.addr   = r_slot;
                    n_out_valid    = 1'b1;
                    n_o_slot       = r_slot;
                    n_o_upd        = r_upd;
                    n_o_count      = r_count;
                    n_o_mean       = MEAN_OUT_W'(r_mean);
                    n_o_dev        = r_dev;
                    n_o_min        = ELAP_W'(r_min);
                    n_o_max        = ELAP_W'(r_max);
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_upd       <= 1'b0;
            r_do_wr     <= 1'b0;
            r_do_clr    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_upd       <= n_upd;
            r_do_wr     <= n_do_wr;
            r_do_clr    <= n_do_clr;
            r_op        <= n_op;
            r_slot      <= n_slot;
            r_ts        <= n_ts;
            r_in_range  <= n_in_range;
            r_start     <= n_start;
            r_running   <= n_running;
            r_count     <= n_count;
            r_mean      <= n_mean;
            r_dev       <= n_dev;
            r_min       <= n_min;
            r_max       <= n_max;
            r_elapsed   <= n_elapsed;
            r_up        <= n_up;
            r_d         <= n_d;
            r_o_slot    <= n_o_slot;
            r_o_upd     <= n_o_upd;
            r_o_count   <= n_o_count;
            r_o_mean    <= n_o_mean;
            r_o_dev     <= n_o_dev;
            r_o_min     <= n_o_min;
            r_o_max     <= n_o_max;
        end
    end

endmodule

FILE: design/its_checker.sv
// Port-level checker for the interval timer bank, bound to the top level.
`include "interval_timer_running_stats_assert.svh"

module its_checker import its_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic [OP_W-1:0]       i_op,
    input logic [SLOT_W-1:0]     i_slot,
    input logic [TS_W-1:0]       i_timestamp,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [SLOT_W-1:0]     o_slot_out,
    input logic                  o_updated,
    input logic [CNT_W-1:0]      o_sample_count,
    input logic [MEAN_OUT_W-1:0] o_mean_fixed,
    input logic [DEV_W-1:0]      o_sq_dev_sum,
    input logic [ELAP_W-1:0]     o_min_elapsed,
    input logic [ELAP_W-1:0]     o_max_elapsed
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pend;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Words accepted whose results are not yet taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(in_acc) - 2'(out_acc);
        end
    end

    `ITS_ASSERT_NOW(a_result_has_source, i_clk, i_rst_n, o_out_valid, r_pend != 2'd0, "result word without an accepted input word")
    `ITS_ASSERT_NOW(a_min_le_max, i_clk, i_rst_n, o_out_valid, o_min_elapsed <= o_max_elapsed, "minimum above maximum")
    `ITS_ASSERT_NOW(a_empty_slot_zero, i_clk, i_rst_n, o_out_valid && (o_sample_count == '0), (o_mean_fixed == '0) && (o_sq_dev_sum == '0) && !o_updated, "empty slot reports nonzero statistics")
    `ITS_ASSERT_NOW(a_update_counts, i_clk, i_rst_n, o_out_valid && o_updated, o_sample_count != '0, "update with zero sample count")
    `ITS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_sample_count) && $stable(o_slot_out), "stalled result word changed")

endmodule

bind interval_timer_running_stats its_checker u_its_checker (.*);

FILE: sim/testbench.sv
// Self-checking testbench for the interval timer bank with per-slot running statistics.
module testbench;
    import its_pkg::*;

    // Run the DUT at its default sizes and mirror those sizes in the predictor.
    localparam int NUM_SLOTS = DEF_NUM_SLOTS;
    localparam int FRAC_BITS = DEF_MEAN_FRAC_BITS;
    localparam int TIME_BITS = DEF_TIME_WIDTH;
    // Shift that brings the exact deviation product (2F fraction bits) to 8 fraction bits.
    localparam int DEV_SHIFT = 2 * FRAC_BITS - 8;
    localparam logic [63:0] STAMP_MASK = (64'd1 << TIME_BITS) - 64'd1;
    // Op code the block leaves unused; it must report statistics and change nothing.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 1250;
    localparam int DRAIN_CYCLES = 100;

    // Statistics word returned for every input word.
    typedef struct packed {
        logic [SLOT_W-1:0]     slot;
        logic                  updated;
        logic [CNT_W-1:0]      count;
        logic [MEAN_OUT_W-1:0] mean;
        logic [DEV_W-1:0]      dev;
        logic [ELAP_W-1:0]     min_e;
        logic [ELAP_W-1:0]     max_e;
    } t_slot_stats;

    // One row of the directed table; fixed holds a hand-typed result when typed is set.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [TS_W-1:0]   ts;
        logic              typed;
        t_slot_stats       fixed;
    } t_dir_row;

    localparam t_slot_stats NO_STATS = '0;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_op = OP_START;
    logic [SLOT_W-1:0]     i_slot = '0;
    logic [TS_W-1:0]       i_timestamp = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [SLOT_W-1:0]     o_slot_out;
    logic                  o_updated;
    logic [CNT_W-1:0]      o_sample_count;
    logic [MEAN_OUT_W-1:0] o_mean_fixed;
    logic [DEV_W-1:0]      o_sq_dev_sum;
    logic [ELAP_W-1:0]     o_min_elapsed;
    logic [ELAP_W-1:0]     o_max_elapsed;

    // Predictor copy of the per-slot state; two-state so it starts at zero like after reset.
    bit        running_q [MAX_SLOTS];
    bit [63:0] start_q   [MAX_SLOTS];
    bit [63:0] count_q   [MAX_SLOTS];
    bit [63:0] mean_q    [MAX_SLOTS];
    bit [63:0] dev_q     [MAX_SLOTS];
    bit [63:0] min_q     [MAX_SLOTS];
    bit [63:0] max_q     [MAX_SLOTS];

    t_slot_stats pending_stats [$];
    t_dir_row    dir_rows [$];

    int mismatch_count = 0;
    int words_checked = 0;
    int samples_added = 0;
    int stops_ignored = 0;
    int slots_cleared = 0;
    int saturated_devs = 0;
    // Set during the quiet stretch: neither side idles then.
    bit calm = 1'b0;

    interval_timer_running_stats #(
        .NUM_SLOTS      (NUM_SLOTS),
        .MEAN_FRAC_BITS (FRAC_BITS),
        .TIME_WIDTH     (TIME_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_slot         (i_slot),
        .i_timestamp    (i_timestamp),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_slot_out     (o_slot_out),
        .o_updated      (o_updated),
        .o_sample_count (o_sample_count),
        .o_mean_fixed   (o_mean_fixed),
        .o_sq_dev_sum   (o_sq_dev_sum),
        .o_min_elapsed  (o_min_elapsed),
        .o_max_elapsed  (o_max_elapsed)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Apply one timer event to the predictor state and return the statistics word it reports.
    // Welford step in fixed point: mean moves by |delta|/n truncated, deviation sum gains
    // delta * (e - new mean) scaled to 8 fraction bits, both sums saturate.
    function automatic t_slot_stats apply_timer_event(input logic [OP_W-1:0] op,
                                                      input logic [SLOT_W-1:0] slot,
                                                      input logic [TS_W-1:0] ts);
        t_slot_stats  res;
        logic [63:0]  stamp, elapsed, prev, n, e, m, d, q, nm, d2, add;
        logic [127:0] prod;
        logic [64:0]  sum;
        logic         up;
        int           s;
        res = NO_STATS;
        res.slot = slot;
        stamp = {32'b0, ts} & STAMP_MASK;
        // Out-of-range slots touch nothing and report zeros.
        if (slot >= NUM_SLOTS)
            return res;
        s = int'(slot);
        case (op)
            OP_START: begin
                running_q[s] = 1'b1;
                start_q[s] = stamp;
            end
            OP_STOP: begin
                // Drop the stop when the slot is idle or the timestamp went backwards.
                if (running_q[s] && stamp >= start_q[s]) begin
                    elapsed = stamp - start_q[s];
                    prev = count_q[s];
                    n = (prev >= 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : prev + 64'd1;
                    e = elapsed << FRAC_BITS;
                    count_q[s] = n;
                    if (prev == 64'd0) begin
                        // First sample seeds every statistic.
                        mean_q[s] = e;
                        dev_q[s] = 64'd0;
                        min_q[s] = elapsed;
                        max_q[s] = elapsed;
                    end else begin
                        m = mean_q[s];
                        up = (e >= m);
                        d = up ? e - m : m - e;
                        q = d / n;
                        nm = up ? m + q : m - q;
                        d2 = up ? e - nm : nm - e;
                        prod = {64'd0, d} * {64'd0, d2};
                        if (DEV_SHIFT >= 0)
                            prod = prod >> (DEV_SHIFT >= 0 ? DEV_SHIFT : 0);
                        else
                            prod = prod << (DEV_SHIFT < 0 ? -DEV_SHIFT : 0);
                        add = (prod[127:64] != 64'd0) ? {64{1'b1}} : prod[63:0];
                        sum = {1'b0, dev_q[s]} + {1'b0, add};
                        dev_q[s] = sum[64] ? {64{1'b1}} : sum[63:0];
                        if (sum[64] || add == {64{1'b1}})
                            saturated_devs++;
                        mean_q[s] = nm;
                        if (elapsed < min_q[s]) min_q[s] = elapsed;
                        if (elapsed > max_q[s]) max_q[s] = elapsed;
                    end
                    res.updated = 1'b1;
                    samples_added++;
                end else begin
                    stops_ignored++;
                end
            end
            OP_CLEAR: begin
                running_q[s] = 1'b0;
                start_q[s] = '0;
                count_q[s] = '0;
                mean_q[s] = '0;
                dev_q[s] = '0;
                min_q[s] = '0;
                max_q[s] = '0;
                slots_cleared++;
            end
            default: ;
        endcase
        res.count = count_q[s][CNT_W-1:0];
        res.mean = mean_q[s][MEAN_OUT_W-1:0];
        res.dev = dev_q[s];
        res.min_e = min_q[s][ELAP_W-1:0];
        res.max_e = max_q[s][ELAP_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s got %h expected %h",
                                      words_checked, name, got, want));
    endtask

    // Table rows: one checked against the predictor, one with the result typed in.
    task automatic row_pred(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                            input logic [TS_W-1:0] ts);
        dir_rows.push_back('{op, slot, ts, 1'b0, NO_STATS});
    endtask

    task automatic row_fixed(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                             input logic [TS_W-1:0] ts, input logic upd,
                             input logic [CNT_W-1:0] cnt, input logic [MEAN_OUT_W-1:0] mean,
                             input logic [DEV_W-1:0] dev, input logic [ELAP_W-1:0] mn,
                             input logic [ELAP_W-1:0] mx);
        dir_rows.push_back('{op, slot, ts, 1'b1, '{slot, upd, cnt, mean, dev, mn, mx}});
    endtask

    // Present one word and hold it until the DUT takes it, then queue what it must return.
    // Called at a rising edge; returns at the edge of acceptance.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                             input logic [TS_W-1:0] ts, input logic typed,
                             input t_slot_stats fixed);
        t_slot_stats predicted;
        i_in_valid <= 1'b1;
        i_op <= op;
        i_slot <= slot;
        i_timestamp <= ts;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_timer_event(op, slot, ts);
        pending_stats.push_back(typed ? fixed : predicted);
    endtask

    // Idle the input side now and then; valid drops only after an accepted word.
    task automatic pause_input();
        if (!calm && $urandom_range(0, 99) < 29) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Output side: take words when not stalling, compare against the oldest expectation,
    // and pick the next cycle's stall.
    always @(posedge i_clk) begin
        t_slot_stats want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_stats.size() == 0) begin
                    report_mismatch($sformatf("word from slot %0d with nothing outstanding",
                                              o_slot_out));
                end else begin
                    want = pending_stats.pop_front();
                    check_field("slot_out", 64'(o_slot_out), 64'(want.slot));
                    check_field("updated", 64'(o_updated), 64'(want.updated));
                    check_field("sample_count", 64'(o_sample_count), 64'(want.count));
                    check_field("mean_fixed", 64'(o_mean_fixed), 64'(want.mean));
                    check_field("sq_dev_sum", o_sq_dev_sum, want.dev);
                    check_field("min_elapsed", 64'(o_min_elapsed), 64'(want.min_e));
                    check_field("max_elapsed", 64'(o_max_elapsed), 64'(want.max_e));
                end
                words_checked++;
            end
            i_out_stall <= !calm && ($urandom_range(0, 99) < 29);
        end
    end

    initial begin
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [TS_W-1:0]   ts;
        logic [63:0]       room, span;
        int                pick;
        int                k;

        // Directed table: idle stops, first samples at the timestamp extremes, backwards
        // stops, repeated stops from one start, the unused op, clears, and a pair of
        // full-range samples that drive the deviation sum into saturation.
        row_fixed(OP_STOP,   5'd0,  32'd100,       1'b0, 0, 0, 0, 0, 0);
        row_fixed(OP_START,  5'd0,  32'd0,         1'b0, 0, 0, 0, 0, 0);
        row_fixed(OP_STOP,   5'd0,  32'd0,         1'b1, 1, 0, 0, 0, 0);
        row_pred (OP_STOP,   5'd0,  32'hFFFF_FFFF);
        row_pred (OP_STOP,   5'd0,  32'd1000);
        row_fixed(OP_START,  5'd31, 32'hFFFF_FFFF, 1'b0, 0, 0, 0, 0, 0);
        row_fixed(OP_STOP,   5'd31, 32'd5,         1'b0, 0, 0, 0, 0, 0);
        row_fixed(OP_STOP,   5'd31, 32'hFFFF_FFFF, 1'b1, 1, 0, 0, 0, 0);
        row_fixed(OP_START,  5'd5,  32'h1000,      1'b0, 0, 0, 0, 0, 0);
        row_fixed(OP_STOP,   5'd5,  32'h1007,      1'b1, 1, 48'h7_0000, 0, 7, 7);
        row_pred (OP_STOP,   5'd5,  32'h1003);
        row_pred (OP_STOP,   5'd5,  32'h1014);
        row_pred (OP_UNUSED, 5'd5,  32'hFFFF_FFFF);
        row_fixed(OP_CLEAR,  5'd5,  32'd0,         1'b0, 0, 0, 0, 0, 0);
        row_fixed(OP_STOP,   5'd5,  32'h2000,      1'b0, 0, 0, 0, 0, 0);
        row_fixed(OP_START,  5'd16, 32'hAAAA_AAAA, 1'b0, 0, 0, 0, 0, 0);
        row_fixed(OP_STOP,   5'd16, 32'hFFFF_FFFF, 1'b1, 1, 48'h5555_5555_0000, 0,
                  32'h5555_5555, 32'h5555_5555);
        row_fixed(OP_START,  5'd20, 32'd0,         1'b0, 0, 0, 0, 0, 0);
        row_fixed(OP_STOP,   5'd20, 32'hFFFF_FFFF, 1'b1, 1, 48'hFFFF_FFFF_0000, 0,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        row_pred (OP_STOP,   5'd20, 32'd0);
        row_pred (OP_STOP,   5'd20, 32'h8000_0000);
        row_pred (OP_UNUSED, 5'd31, 32'h5555_5555);
        row_fixed(OP_CLEAR,  5'd0,  32'hFFFF_FFFF, 1'b0, 0, 0, 0, 0, 0);
        row_fixed(OP_CLEAR,  5'd31, 32'd0,         1'b0, 0, 0, 0, 0, 0);

        // Hold reset low, then release it ahead of the directed table.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_word(dir_rows[r].op, dir_rows[r].slot, dir_rows[r].ts,
                      dir_rows[r].typed, dir_rows[r].fixed);
            pause_input();
        end

        // Random part: mostly well-formed start/stop runs on a few busy slots so the
        // statistics build up over many samples, with backwards stops, stops on any
        // slot, clears and the unused op mixed in as noise.
        for (k = 0; k < RANDOM_WORDS; k++) begin
            calm = (k >= 400 && k < 650);
            slot = ($urandom_range(0, 99) < 60) ? SLOT_W'($urandom_range(0, 3))
                                                : SLOT_W'($urandom_range(0, 31));
            pick = $urandom_range(0, 99);
            if (pick < 18 || (pick < 83 && !running_q[slot])) begin
                op = OP_START;
                ts = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h000F_FFFF);
            end else if (pick < 78) begin
                // Advance from the recorded start; keep the stop inside the counter range.
                op = OP_STOP;
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    span = 64'($urandom_range(0, 200));
                else if (pick < 85)
                    span = 64'($urandom_range(0, 32'h000F_FFFF));
                else
                    span = 64'($urandom);
                room = 64'hFFFF_FFFF - start_q[slot];
                if (span > room)
                    span = room;
                ts = TS_W'(start_q[slot] + span);
            end else if (pick < 83) begin
                op = OP_STOP;
                ts = (start_q[slot] == 0) ? $urandom
                                          : $urandom_range(0, 32'(start_q[slot] - 64'd1));
            end else if (pick < 88) begin
                op = OP_STOP;
                slot = SLOT_W'($urandom_range(0, 31));
                ts = $urandom;
            end else if (pick < 95) begin
                op = OP_CLEAR;
                ts = $urandom;
            end else begin
                op = OP_UNUSED;
                ts = $urandom;
            end
            send_word(op, slot, ts, 1'b0, NO_STATS);
            pause_input();
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Drain: wait for every outstanding word, then watch a while for strays.
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d words checked, %0d samples added, %0d stops dropped,",
                 words_checked, samples_added, stops_ignored);
        $display("         %0d slot clears, %0d saturating deviation updates, %0d mismatches",
                 slots_cleared, saturated_devs, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("Timeout with %0d words outstanding", pending_stats.size());
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/its_pkg.sv
design/its_store.sv
design/its_div.sv
design/its_mul.sv
design/interval_timer_running_stats.sv
design/its_checker.sv
sim/testbench.sv
